FILE: design/lcdmls_pkg.sv
// Shared types and timing constants for the LCD mode and line sequencer.
package lcdmls_pkg;

    // Display modes, encoded as the status register shows them.
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } mode_t;

    // Mode lengths in machine cycles.
    localparam logic [15:0] LEN_HBLANK      = 16'd204;
    localparam logic [15:0] LEN_VBLANK_LINE = 16'd456;
    localparam logic [15:0] LEN_OAM         = 16'd80;
    localparam logic [15:0] LEN_TRANSFER    = 16'd172;

    // Line numbers.
    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_VBLANK_LINE  = 8'd153;
    localparam logic [7:0] RESET_LINE        = 8'h91;

    // Configuration register indexes.
    localparam logic [7:0] CFG_COMPARE_LINE       = 8'd0;
    localparam logic [7:0] CFG_HBLANK_IRQ_ENABLE  = 8'd1;
    localparam logic [7:0] CFG_OAM_IRQ_ENABLE     = 8'd2;
    localparam logic [7:0] CFG_COMPARE_IRQ_ENABLE = 8'd3;

endpackage

FILE: design/lcd_mode_line_sequencer.sv
// LCD mode and line sequencer: steps display modes and lines from elapsed cycle counts.
// A request accepted at one clock edge shows its result on the m_ channel right
// after that edge. Throughput: one request per cycle unless the result channel stalls; the
// mode, line and accumulator registers update in the accept cycle through one add, one
// compare and one subtract. Reset (aresetn low, synchronous) empties the result
// register, clears all configuration, and puts the sequencer in vertical blank, line 145.
module lcd_mode_line_sequencer
    import lcdmls_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    // Configuration write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,

    // Input request channel.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_cycles_added,

    // Result channel.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_mode,
    output logic [7:0] m_line,
    output logic       m_render_strobe,
    output logic [7:0] m_render_row,
    output logic       m_status_irq,
    output logic       m_vblank_irq,
    output logic       m_compare_match
);

    // Configuration registers.
    logic [7:0]  compare_line_reg;
    logic        hblank_irq_enable_reg;
    logic        oam_irq_enable_reg;
    logic        compare_irq_enable_reg;

    // Sequencer state.
    logic [15:0] acc_reg, acc_next;
    mode_t       mode_reg, mode_next;
    logic [7:0]  line_reg, line_next;
    logic        match_reg, match_next;

    // Result register.
    logic        m_valid_reg;
    logic        strobe_reg, strobe_next;
    logic [7:0]  row_reg, row_next;
    logic        stat_reg, stat_next;
    logic        vbl_reg, vbl_next;

    logic        in_accept;
    logic [16:0] sum_wide;
    logic [15:0] acc_sat;
    logic [7:0]  line_inc;

    // Configuration writes are always taken; the user must send them only while idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compare_line_reg       <= '0;
            hblank_irq_enable_reg  <= 1'b0;
            oam_irq_enable_reg     <= 1'b0;
            compare_irq_enable_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COMPARE_LINE:       compare_line_reg       <= cfg_data;
                CFG_HBLANK_IRQ_ENABLE:  hblank_irq_enable_reg  <= cfg_data[0];
                CFG_OAM_IRQ_ENABLE:     oam_irq_enable_reg     <= cfg_data[0];
                CFG_COMPARE_IRQ_ENABLE: compare_irq_enable_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A new request is taken whenever the result register is empty or is being
    // drained in this same cycle, so requests flow at one per clock.
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // Saturating accumulate of the elapsed cycles.
    assign sum_wide = {1'b0, acc_reg} + {9'd0, s_cycles_added};
    assign acc_sat  = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
    assign line_inc = line_reg + 8'd1;

    // At most one mode transition per request. When the current mode's length
    // has elapsed, that length is taken off the accumulator and the mode moves on.
    always_comb begin
        acc_next    = acc_sat;
        mode_next   = mode_reg;
        line_next   = line_reg;
        match_next  = match_reg;
        strobe_next = 1'b0;
        row_next    = '0;
        stat_next   = 1'b0;
        vbl_next    = 1'b0;
        case (mode_reg)
            MODE_HBLANK: begin
                // End of a visible line: hand the row to the renderer.
                if (acc_sat >= LEN_HBLANK) begin
                    acc_next    = acc_sat - LEN_HBLANK;
                    strobe_next = 1'b1;
                    row_next    = line_reg;
                    line_next   = line_inc;
                    stat_next   = hblank_irq_enable_reg;
                    mode_next   = (line_inc == FIRST_VBLANK_LINE) ? MODE_VBLANK : MODE_OAM;
                end
            end
            MODE_VBLANK: begin
                if (acc_sat >= LEN_VBLANK_LINE) begin
                    acc_next = acc_sat - LEN_VBLANK_LINE;
                    // The frame is ready once the first blank line has run.
                    vbl_next = (line_reg == FIRST_VBLANK_LINE);
                    if (line_reg == LAST_VBLANK_LINE) begin
                        line_next = '0;
                        mode_next = MODE_OAM;
                    end else begin
                        line_next = line_inc;
                    end
                end
            end
            MODE_OAM: begin
                // The line compare flag is refreshed only at the end of OAM scan.
                if (acc_sat >= LEN_OAM) begin
                    acc_next   = acc_sat - LEN_OAM;
                    mode_next  = MODE_TRANSFER;
                    match_next = (line_reg == compare_line_reg);
                    stat_next  = oam_irq_enable_reg
                              || (compare_irq_enable_reg && (line_reg == compare_line_reg));
                end
            end
            MODE_TRANSFER: begin
                if (acc_sat >= LEN_TRANSFER) begin
                    acc_next  = acc_sat - LEN_TRANSFER;
                    mode_next = MODE_HBLANK;
                end
            end
            default: begin
                acc_next = acc_sat;
            end
        endcase
    end

    // State registers advance once per accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            mode_reg  <= MODE_VBLANK;
            line_reg  <= RESET_LINE;
            match_reg <= 1'b0;
        end else if (in_accept) begin
            acc_reg   <= acc_next;
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            match_reg <= match_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload; the strobes are part of the result, not free-running.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            strobe_reg <= strobe_next;
            row_reg    <= row_next;
            stat_reg   <= stat_next;
            vbl_reg    <= vbl_next;
        end
    end

    // Mode, line and match flag are shown straight from the state registers,
    // which hold the values after the last accepted request.
    assign m_valid         = m_valid_reg;
    assign m_mode          = mode_reg;
    assign m_line          = line_reg;
    assign m_render_strobe = strobe_reg;
    assign m_render_row    = row_reg;
    assign m_status_irq    = stat_reg;
    assign m_vblank_irq    = vbl_reg;
    assign m_compare_match = match_reg;

endmodule

FILE: design/lcdmls_checker.sv
// Port-level assertions for the LCD mode and line sequencer, with their bind.
module lcdmls_checker
    import lcdmls_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_mode,
    input logic [7:0] m_line,
    input logic       m_render_strobe,
    input logic [7:0] m_render_row,
    input logic       m_vblank_irq
);

    // After reset no result is shown.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its line.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line))
        else $error("stalled result changed");

    // A finished row is always the line just before the new current line.
    a_row_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_render_strobe |-> m_line == 8'(m_render_row + 8'd1))
        else $error("render row does not precede line");

    // After a row is finished the sequencer is in OAM scan or vertical blank.
    a_row_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_render_strobe
            |-> (m_mode == MODE_OAM) || (m_mode == MODE_VBLANK))
        else $error("render strobe in wrong mode");

    // Frame ready comes only as the first blank line ends.
    a_vblank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_vblank_irq |-> m_mode == MODE_VBLANK && m_line == 8'd145)
        else $error("vertical blank strobe at wrong line");

endmodule

bind lcd_mode_line_sequencer lcdmls_checker u_lcdmls_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_mode          (m_mode),
    .m_line          (m_line),
    .m_render_strobe (m_render_strobe),
    .m_render_row    (m_render_row),
    .m_vblank_irq    (m_vblank_irq)
);

FILE: dv/lcd_mode_line_sequencer_tb.sv
// Self-checking testbench for the LCD mode and line sequencer, with its own line-timing predictor.
module lcd_mode_line_sequencer_tb;
    import lcdmls_pkg::*;

    // One result of the sequencer, field for field as the m_ channel carries it.
    typedef struct packed {
        mode_t      mode;
        logic [7:0] line;
        logic       render_strobe;
        logic [7:0] render_row;
        logic       status_irq;
        logic       vblank_irq;
        logic       compare_match;
    } line_event_t;

    logic       aclk = 1'b0;
    logic       aresetn;

    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_cycles_added;

    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_mode;
    logic [7:0] m_line;
    logic       m_render_strobe;
    logic [7:0] m_render_row;
    logic       m_status_irq;
    logic       m_vblank_irq;
    logic       m_compare_match;

    // Line events predicted for accepted requests, oldest first.
    line_event_t pending_events[$];
    int          error_count = 0;

    // When set, neither side inserts idle cycles, so requests run back to back.
    bit          calm = 1'b0;

    // Shadow copies of the configuration registers.
    logic [7:0]  sh_compare_line;
    logic        sh_hblank_en;
    logic        sh_oam_en;
    logic        sh_cmp_en;

    // Shadow copy of the sequencer state.
    logic [15:0] sh_cycles;
    mode_t       sh_mode;
    logic [7:0]  sh_line;
    logic        sh_match;

    lcd_mode_line_sequencer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cycles_added  (s_cycles_added),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mode          (m_mode),
        .m_line          (m_line),
        .m_render_strobe (m_render_strobe),
        .m_render_row    (m_render_row),
        .m_status_irq    (m_status_irq),
        .m_vblank_irq    (m_vblank_irq),
        .m_compare_match (m_compare_match)
    );

    always #4 aclk = ~aclk;

    // Advances the shadow sequencer by one request and returns the event it produces.
    // The accumulator saturates first; then at most one mode ends, paying for its length.
    function automatic line_event_t advance_sequencer(input logic [7:0] added);
        line_event_t ev;
        logic [16:0] sum;
        ev  = '0;
        sum = {1'b0, sh_cycles} + {9'd0, added};
        sh_cycles = sum[16] ? 16'hFFFF : sum[15:0];
        case (sh_mode)
            MODE_HBLANK: begin
                // The row is finished: strobe it and move to the next line.
                if (sh_cycles >= LEN_HBLANK) begin
                    sh_cycles        = sh_cycles - LEN_HBLANK;
                    ev.render_strobe = 1'b1;
                    ev.render_row    = sh_line;
                    sh_line          = sh_line + 8'd1;
                    ev.status_irq    = sh_hblank_en;
                    sh_mode          = (sh_line == FIRST_VBLANK_LINE) ? MODE_VBLANK : MODE_OAM;
                end
            end
            MODE_VBLANK: begin
                // The frame-ready strobe fires when the first blank line ends; the last
                // blank line wraps back to line zero and a new frame starts with OAM scan.
                if (sh_cycles >= LEN_VBLANK_LINE) begin
                    sh_cycles     = sh_cycles - LEN_VBLANK_LINE;
                    ev.vblank_irq = (sh_line == FIRST_VBLANK_LINE);
                    if (sh_line == LAST_VBLANK_LINE) begin
                        sh_line = 8'd0;
                        sh_mode = MODE_OAM;
                    end else begin
                        sh_line = sh_line + 8'd1;
                    end
                end
            end
            MODE_OAM: begin
                // The compare flag is only refreshed here and held everywhere else.
                if (sh_cycles >= LEN_OAM) begin
                    sh_cycles     = sh_cycles - LEN_OAM;
                    sh_mode       = MODE_TRANSFER;
                    sh_match      = (sh_line == sh_compare_line);
                    ev.status_irq = sh_oam_en | (sh_cmp_en & sh_match);
                end
            end
            default: begin
                if (sh_cycles >= LEN_TRANSFER) begin
                    sh_cycles = sh_cycles - LEN_TRANSFER;
                    sh_mode   = MODE_HBLANK;
                end
            end
        endcase
        ev.mode          = sh_mode;
        ev.line          = sh_line;
        ev.compare_match = sh_match;
        return ev;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Cycle counts biased toward the extremes and toward the mode lengths, where the
    // compare against the accumulator flips.
    function automatic logic [7:0] pick_cycles();
        int r;
        int base;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'd0;
        if (r < 18)
            return 8'd255;
        if (r < 30)
            return 8'($urandom_range(0, 15));
        if (r < 42) begin
            case (r % 3)
                0:       base = LEN_OAM;
                1:       base = LEN_TRANSFER;
                default: base = LEN_HBLANK;
            endcase
            return 8'(base + $urandom_range(0, 4) - 2);
        end
        return 8'($urandom);
    endfunction

    // Sends one request. Valid is left high after acceptance so that a request with no
    // gap follows at once; it is lowered only when a gap is taken or the side drains.
    task automatic send_cycles(input logic [7:0] added);
        int gap;
        line_event_t ev;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cycles_added <= added;
        do @(posedge aclk); while (!s_ready);
        ev = advance_sequencer(added);
        pending_events = {pending_events, ev};
    endtask

    // Stops sending and waits until every predicted event has been seen.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    // Writes all four registers back to back, plus one write to an unused index that
    // must change nothing. The enable bits carry random upper bits that must be masked.
    task automatic write_config(input logic [7:0] cmp_line, input logic hb_en,
                                input logic oam_en, input logic cmp_en);
        logic [7:0] reg_index [5];
        logic [7:0] reg_data  [5];
        reg_index[0] = CFG_COMPARE_LINE;       reg_data[0] = cmp_line;
        reg_index[1] = CFG_HBLANK_IRQ_ENABLE;  reg_data[1] = {7'($urandom), hb_en};
        reg_index[2] = CFG_OAM_IRQ_ENABLE;     reg_data[2] = {7'($urandom), oam_en};
        reg_index[3] = CFG_COMPARE_IRQ_ENABLE; reg_data[3] = {7'($urandom), cmp_en};
        reg_index[4] = 8'($urandom_range(255, CFG_COMPARE_IRQ_ENABLE + 1));
        reg_data[4]  = 8'($urandom);
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[i];
            cfg_data  <= reg_data[i];
            do @(posedge aclk); while (!cfg_ready);
            case (reg_index[i])
                CFG_COMPARE_LINE:       sh_compare_line = reg_data[i];
                CFG_HBLANK_IRQ_ENABLE:  sh_hblank_en    = reg_data[i][0];
                CFG_OAM_IRQ_ENABLE:     sh_oam_en       = reg_data[i][0];
                CFG_COMPARE_IRQ_ENABLE: sh_cmp_en       = reg_data[i][0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // From reset the sequencer sits in blank line 145. Full-size counts walk it through
    // the remaining blank lines, across the wrap after the last one to line zero, and
    // then through OAM scan, transfer and the end of horizontal blank on row zero. With
    // the compare line at zero and every enable set, that OAM end both matches and
    // interrupts, and the finished row raises the horizontal-blank interrupt.
    task automatic test_directed_frame_wrap();
        write_config(8'd0, 1'b1, 1'b1, 1'b1);
        send_cycles(8'd0);
        repeat (22) send_cycles(8'd255);
        send_cycles(8'd0);
        send_cycles(8'd128);
        wait_drained();
    endtask

    // Random requests in phases, each with its own register setting. The first two
    // phases use the extremes (everything off with the top compare line, everything on
    // with compare line zero); the next three aim the compare line one to four lines ahead
    // so a match is met in the phase, and the last sets it at random. One phase never idles.
    task automatic test_random_phases();
        logic [7:0] cmp;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_config(8'd255, 1'b0, 1'b0, 1'b0);
                1: write_config(8'd0, 1'b1, 1'b1, 1'b1);
                default: begin
                    cmp = (p == 5) ? 8'($urandom) : 8'(sh_line + $urandom_range(1, 4));
                    write_config(cmp, 1'($urandom), 1'($urandom), 1'($urandom));
                end
            endcase
            calm = (p == 3);
            repeat (30) send_cycles(pick_cycles());
            wait_drained();
        end
        calm = 1'b0;
    endtask

    // Full-size counts outrun the mode lengths during visible lines, so the accumulator
    // climbs with each request there until it pins at its maximum.
    // A tail of mixed counts then runs with the accumulator at or near saturation.
    task automatic test_accumulator_saturation();
        write_config(8'(sh_line + 8'd3), 1'b1, 1'b0, 1'b1);
        repeat (720) send_cycles(8'd255);
        repeat (30) send_cycles(pick_cycles());
        wait_drained();
    endtask

    // Result side: ready drops for random stretches, with bursts of ready between.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            int stall;
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin : check_results
        line_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $error("result with no request pending: mode %0d line %0d", m_mode, m_line);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("mode",          8'(want.mode),          8'(m_mode));
                check_field("line",          want.line,              m_line);
                check_field("render_strobe", 8'(want.render_strobe), 8'(m_render_strobe));
                check_field("render_row",    want.render_row,        m_render_row);
                check_field("status_irq",    8'(want.status_irq),    8'(m_status_irq));
                check_field("vblank_irq",    8'(want.vblank_irq),    8'(m_vblank_irq));
                check_field("compare_match", 8'(want.compare_match), 8'(m_compare_match));
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_cycles_added = '0;

        // Shadow state as the block leaves reset.
        sh_compare_line = '0;
        sh_hblank_en    = 1'b0;
        sh_oam_en       = 1'b0;
        sh_cmp_en       = 1'b0;
        sh_cycles       = '0;
        sh_mode         = MODE_VBLANK;
        sh_line         = RESET_LINE;
        sh_match        = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_frame_wrap();
        test_random_phases();
        test_accumulator_saturation();

        // Keep the clock running before the verdict so that any stray result is caught.
        repeat (4) @(posedge aclk);
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: a correct run with every stall at its longest ends well before this.
    initial begin
        #6000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
